FILE: hdl/sorted_table_binary_search_macros.svh
// Assertion macros shared by the sorted table search modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define STBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside of reset.
`define STBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/stbs_pkg.sv
// Shared types and constants of the sorted table binary search block.
// Depends on nothing; used by the controller, the datapath and the top level.
package stbs_pkg;

	// Fixed field widths of the stream items.
	localparam int OPCODE_W = 2;
	localparam int IDX_W    = 10;
	localparam int WORD_W   = 32;
	localparam int LEN_W    = 11;
	localparam int POS_W    = 10;

	// Input tdata layout, lowest field first.
	localparam int ENTRY_INDEX_LSB = 0;
	localparam int ENTRY_VALUE_LSB = ENTRY_INDEX_LSB + IDX_W;
	localparam int SEARCH_KEY_LSB  = ENTRY_VALUE_LSB + WORD_W;
	localparam int S_TDATA_W       = 80;
	localparam int M_TDATA_W       = 16;

	typedef enum logic [OPCODE_W-1:0] {
		OP_WRITE = 2'd0,
		OP_EXACT = 2'd1,
		OP_FIRST = 2'd2,
		OP_LAST  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_COMPARE,
		ST_FINAL,
		ST_DONE
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_en;     // store the incoming entry
		logic start;     // capture key and mode, open the search range
		logic rd_probe;  // read the table at the midpoint
		logic step;      // narrow the range by the probe result
		logic rd_final;  // read the table at the bound candidate
		logic check;     // resolve the bound candidate
		logic out_load;  // move the result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		opcode_t op;          // mode of the search in flight
		logic    range_empty; // no index left to probe
		logic    final_ok;    // bound candidate lies inside the table
		logic    probe_eq;    // probed entry equals the key
		logic    out_free;    // output register can take a result
	} sts_t;

endpackage

FILE: hdl/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
// Depends on stbs_pkg, stbs_ctrl and stbs_dpath.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tuser: opcode; tdata: index, value, key
//  m_*      | out       | m_tvalid/m_tready  | tuser: found; tdata: position
//  cfg_*    | in        | cfg_valid/cfg_ready| table_length
//
// A write transaction is stored straight from the idle state. A search runs one probe
// at a time, first the registered table read and then the narrowing of the range;
// the single table read port sets this sequence.
// Reset clears the length register, the sequencer and the output valid; the table is not cleared.
// A stalled output holds its result; a new search may run meanwhile and waits
// for the output register before it completes.
module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [stbs_pkg::S_TDATA_W-1:0]  s_tdata,   // entry_index, entry_value, search_key
	input  logic [stbs_pkg::OPCODE_W-1:0]   s_tuser,   // opcode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [stbs_pkg::M_TDATA_W-1:0]  m_tdata,   // position
	output logic [0:0]                      m_tuser,   // found
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [stbs_pkg::LEN_W-1:0]      cfg_data
);
	import stbs_pkg::*;

	cmd_t    cmd;
	sts_t    sts;
	opcode_t in_op;
	logic    found;

	assign in_op     = opcode_t'(s_tuser);
	assign cfg_ready = 1'b1;
	assign m_tuser   = found;

	// Sequencer.
	stbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_op    (in_op),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Table, bounds and output register.
	stbs_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_op     (in_op),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_found   (found)
	);

endmodule

FILE: hdl/stbs_ctrl.sv
// Search sequencer of the sorted table binary search block.
// Depends on stbs_pkg and on the assertion macros header.
`include "sorted_table_binary_search_macros.svh"

module stbs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  stbs_pkg::opcode_t in_op,
	input  stbs_pkg::sts_t   sts,
	output stbs_pkg::cmd_t   cmd
);
	import stbs_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (in_op == OP_WRITE) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = ST_PROBE;
					end
				end
			end
			ST_PROBE: begin
				if (sts.range_empty) begin
					if (sts.op == OP_EXACT) begin
						state_d = ST_DONE;
					end else if (sts.final_ok) begin
						cmd.rd_final = 1'b1;
						state_d      = ST_FINAL;
					end else begin
						state_d = ST_DONE;
					end
				end else begin
					cmd.rd_probe = 1'b1;
					state_d      = ST_COMPARE;
				end
			end
			ST_COMPARE: begin
				cmd.step = 1'b1;
				if (sts.probe_eq && sts.op == OP_EXACT) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_PROBE;
				end
			end
			ST_FINAL: begin
				cmd.check = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A search transaction always enters the probe loop next.
	`STBS_ASSERT_NEXT(a_start_probe, clk, arst_n, s_tvalid && s_tready && in_op != OP_WRITE, state_q == ST_PROBE, "search did not enter probe loop")
	// A result never overwrites one that is still waiting.
	`STBS_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.out_load, sts.out_free, "result register overwritten")
	// The bound candidate read stays inside the searched entries.
	`STBS_ASSERT_NOW(a_final_in_range, clk, arst_n, cmd.rd_final, sts.final_ok && sts.op != OP_EXACT, "bound read out of range")

endmodule

FILE: hdl/stbs_dpath.sv
// Datapath of the sorted table binary search block: table memory, length
// register, search bounds, comparator and output register. Depends on stbs_pkg and the macros header.
`include "sorted_table_binary_search_macros.svh"

module stbs_dpath #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  stbs_pkg::cmd_t                   cmd,
	output stbs_pkg::sts_t                   sts,
	input  stbs_pkg::opcode_t                in_op,
	input  logic [stbs_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                             cfg_valid,
	input  logic [stbs_pkg::LEN_W-1:0]       cfg_data,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [stbs_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                             m_found
);
	import stbs_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LW = $clog2(TABLE_DEPTH + 1);
	localparam int CW = LW + LEN_W;

	// Table storage, read data registered.
	logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
	logic [VALUE_WIDTH-1:0] rd_data_q;

	logic [LEN_W-1:0]       tlen_q;
	logic [LW-1:0]          len_q;
	logic [LW-1:0]          left_q;
	logic [LW-1:0]          hi_q;
	logic [LW-1:0]          mid_q;
	logic [VALUE_WIDTH-1:0] key_q;
	opcode_t                op_q;
	logic                   res_found_q;
	logic [POS_W-1:0]       res_pos_q;
	logic                   m_valid_q;
	logic                   m_found_q;
	logic [POS_W-1:0]       m_pos_q;

	logic [IDX_W-1:0]        in_idx;
	logic [WORD_W-1:0]       in_value;
	logic [WORD_W-1:0]       in_key;
	logic [VALUE_WIDTH+WORD_W-1:0] value_ext;
	logic [VALUE_WIDTH+WORD_W-1:0] key_ext;
	logic [IDX_W+AW-1:0]     idx_ext;
	logic                    wr_in_range;
	logic [CW-1:0]           tlen_ext;
	logic [CW-1:0]           len_sat;
	logic [LW-1:0]           diff;
	logic [LW-1:0]           mid;
	logic [LW-1:0]           hi_m1;
	logic [LW-1:0]           fin_idx;
	logic [AW-1:0]           rd_addr;
	logic                    probe_lt;
	logic                    probe_eq;
	logic [AW+POS_W-1:0]     mid_pos_ext;
	logic [AW+POS_W-1:0]     fin_pos_ext;

	// Field extraction and sign extension or wrap of the values to the stored width.
	assign in_idx    = s_tdata[ENTRY_INDEX_LSB +: IDX_W];
	assign in_value  = s_tdata[ENTRY_VALUE_LSB +: WORD_W];
	assign in_key    = s_tdata[SEARCH_KEY_LSB +: WORD_W];
	assign value_ext = {{VALUE_WIDTH{in_value[WORD_W-1]}}, in_value};
	assign key_ext   = {{VALUE_WIDTH{in_key[WORD_W-1]}}, in_key};

	// Writes at or beyond the table depth are dropped.
	assign idx_ext     = {{AW{1'b0}}, in_idx};
	assign wr_in_range = idx_ext < (IDX_W + AW)'(TABLE_DEPTH);

	// Configured length saturated to the table depth.
	assign tlen_ext = {{LW{1'b0}}, tlen_q};
	assign len_sat  = (tlen_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : tlen_ext;

	// Midpoint of the half-open range [left, hi).
	assign diff  = hi_q - left_q - LW'(1);
	assign mid   = left_q + (diff >> 1);
	assign hi_m1 = hi_q - LW'(1);

	// Bound candidate: leftmost uses left, rightmost uses the last index kept.
	assign fin_idx = (op_q == OP_FIRST) ? left_q : hi_m1;
	assign rd_addr = cmd.rd_final ? fin_idx[AW-1:0] : mid[AW-1:0];

	// Signed comparison of the probed entry against the key.
	assign probe_lt = $signed(rd_data_q) < $signed(key_q);
	assign probe_eq = rd_data_q == key_q;

	assign mid_pos_ext = {{POS_W{1'b0}}, mid_q[AW-1:0]};
	assign fin_pos_ext = {{POS_W{1'b0}}, fin_idx[AW-1:0]};

	// Table memory port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_in_range) begin
			mem[idx_ext[AW-1:0]] <= value_ext[VALUE_WIDTH-1:0];
		end
		if (cmd.rd_probe || cmd.rd_final) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Length register written by the configuration channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q <= '0;
		end else if (cfg_valid) begin
			tlen_q <= cfg_data;
		end
	end

	// Search bounds, key and running result.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q        <= in_op;
			key_q       <= key_ext[VALUE_WIDTH-1:0];
			len_q       <= len_sat[LW-1:0];
			left_q      <= '0;
			hi_q        <= len_sat[LW-1:0];
			res_found_q <= 1'b0;
			res_pos_q   <= '0;
		end
		if (cmd.rd_probe) begin
			mid_q <= mid;
		end
		if (cmd.step) begin
			if (probe_lt) begin
				left_q <= mid_q + LW'(1);
			end else if (!probe_eq) begin
				hi_q <= mid_q;
			end else if (op_q == OP_EXACT) begin
				res_found_q <= 1'b1;
				res_pos_q   <= mid_pos_ext[POS_W-1:0];
			end else if (op_q == OP_FIRST) begin
				hi_q <= mid_q;
			end else begin
				left_q <= mid_q + LW'(1);
			end
		end
		if (cmd.check && probe_eq) begin
			res_found_q <= 1'b1;
			res_pos_q   <= fin_pos_ext[POS_W-1:0];
		end
	end

	// Output register: valid is control, payload loads with it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_found_q <= res_found_q;
			m_pos_q   <= res_pos_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_found  = m_found_q;
	assign m_tdata  = {{(M_TDATA_W - POS_W){1'b0}}, m_pos_q};

	// Status toward the controller.
	always_comb begin
		sts.op          = op_q;
		sts.range_empty = left_q >= hi_q;
		sts.final_ok    = (op_q == OP_FIRST) ? (left_q < len_q) : (hi_q != '0);
		sts.probe_eq    = probe_eq;
		sts.out_free    = !m_valid_q || m_tready;
	end

	// Every probed midpoint lies inside the half-open range.
	`STBS_ASSERT_NOW(a_mid_in_range, clk, arst_n, cmd.step, mid_q >= left_q && mid_q < hi_q, "midpoint outside range")
	// An exact hit on a probe is reported as found.
	`STBS_ASSERT_NEXT(a_exact_hit, clk, arst_n, cmd.step && op_q == OP_EXACT && probe_eq, res_found_q, "exact hit lost")
	// A miss always reports position zero.
	`STBS_ASSERT_NOW(a_miss_pos_zero, clk, arst_n, m_valid_q && !m_found_q, m_pos_q == '0, "miss with nonzero position")

endmodule
